/* sv/cvcs_pkg.sv */
// Shared types and codes for the covariance chi-square core.
`default_nettype none
package cvcs_pkg;

    // Input item kinds carried in tuser
    localparam logic MODE_MATRIX = 1'b0;
    localparam logic MODE_BIN    = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_INVERSE = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_SIZE  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_VALID = 4'd1;

    // Field widths
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned MAT_W   = 32;
    localparam int unsigned OPER_W  = 34;
    localparam int unsigned PROD_W  = 68;
    localparam int unsigned ACC_W   = 128;
    localparam int unsigned CHISQ_W = 64;
    localparam int unsigned LO_W    = 33;

    // Multiplier operand selection
    localparam logic [1:0] MUL_NONE = 2'd0;
    localparam logic [1:0] MUL_DD   = 2'd1;
    localparam logic [1:0] MUL_LO   = 2'd2;
    localparam logic [1:0] MUL_HI   = 2'd3;

    // Accumulator operation
    localparam logic [2:0] ADD_NONE  = 3'd0;
    localparam logic [2:0] ADD_LO    = 3'd1;
    localparam logic [2:0] ADD_HI    = 3'd2;
    localparam logic [2:0] ADD_HALF  = 3'd3;
    localparam logic [2:0] ADD_CLEAR = 3'd4;

    typedef struct packed {
        logic [1:0] mul_sel;
        logic [2:0] add_sel;
    } mac_ctrl_t;

endpackage
`default_nettype wire

/* sv/cvcs_mem.sv */
// Inverse matrix store and difference store with registered read ports.
`default_nettype none
module cvcs_mem #(
    parameter int MAX_BINS = 64,
    localparam int DEPTH   = MAX_BINS * MAX_BINS,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int IW      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             inv_we,
    input  wire logic [AW-1:0]                    inv_waddr,
    input  wire logic [cvcs_pkg::MAT_W-1:0]       inv_wdata,
    input  wire logic                             diff_we,
    input  wire logic [IW-1:0]                    diff_waddr,
    input  wire logic [cvcs_pkg::DIFF_W-1:0]      diff_wdata,
    input  wire logic                             rd_en,
    input  wire logic [AW-1:0]                    inv_raddr,
    input  wire logic [IW-1:0]                    rd_i,
    input  wire logic [IW-1:0]                    rd_j,
    output logic      [cvcs_pkg::MAT_W-1:0]       m_val,
    output logic      [cvcs_pkg::DIFF_W-1:0]      d_i,
    output logic      [cvcs_pkg::DIFF_W-1:0]      d_j
);
    logic [cvcs_pkg::MAT_W-1:0]  inv_mem  [DEPTH];
    logic [cvcs_pkg::DIFF_W-1:0] diff_mem [MAX_BINS];

    // Write and read the matrix store
    always_ff @(posedge clk)
    begin
        if (inv_we)
        begin
            inv_mem[inv_waddr] <= inv_wdata;
        end
        if (rd_en)
        begin
            m_val <= inv_mem[inv_raddr];
        end
    end

    // Write and read the difference store at two addresses
    always_ff @(posedge clk)
    begin
        if (diff_we)
        begin
            diff_mem[diff_waddr] <= diff_wdata;
        end
        if (rd_en)
        begin
            d_i <= diff_mem[rd_i];
            d_j <= diff_mem[rd_j];
        end
    end

endmodule
`default_nettype wire

/* sv/cvcs_mac.sv */
// Shared 34x34 multiplier with 128-bit accumulator, rounding and saturation.
`default_nettype none
module cvcs_mac #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire cvcs_pkg::mac_ctrl_t           ctrl,
    input  wire logic [cvcs_pkg::DIFF_W-1:0]   d_i,
    input  wire logic [cvcs_pkg::DIFF_W-1:0]   d_j,
    input  wire logic [cvcs_pkg::MAT_W-1:0]    m_val,
    output logic      [cvcs_pkg::CHISQ_W-1:0]  result
);
    localparam int HALF_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam logic [cvcs_pkg::ACC_W-1:0] HALF_C =
        (FRAC_BITS > 0) ? (128'd1 << HALF_SH) : 128'd0;

    logic signed [cvcs_pkg::OPER_W-1:0] op_a;
    logic signed [cvcs_pkg::OPER_W-1:0] op_b;
    logic signed [cvcs_pkg::PROD_W-1:0] mul_out;
    logic        [cvcs_pkg::PROD_W-1:0] prod_reg;
    logic        [cvcs_pkg::LO_W-1:0]   hi_reg;
    logic        [cvcs_pkg::ACC_W-1:0]  acc_reg;
    logic        [cvcs_pkg::ACC_W-1:0]  acc_next;
    logic        [cvcs_pkg::ACC_W-1:0]  addend;
    logic signed [cvcs_pkg::ACC_W-1:0]  shifted;
    logic                               fits;

    // Select multiplier operands
    always_comb
    begin
        op_a = '0;
        op_b = {{2{m_val[cvcs_pkg::MAT_W-1]}}, m_val};
        case (ctrl.mul_sel)
            cvcs_pkg::MUL_DD:
            begin
                op_a = {d_i[cvcs_pkg::DIFF_W-1], d_i};
                op_b = {d_j[cvcs_pkg::DIFF_W-1], d_j};
            end
            cvcs_pkg::MUL_LO:
            begin
                op_a = {1'b0, prod_reg[cvcs_pkg::LO_W-1:0]};
            end
            cvcs_pkg::MUL_HI:
            begin
                op_a = {hi_reg[cvcs_pkg::LO_W-1], hi_reg};
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    assign mul_out = op_a * op_b;

    // Select accumulator addend
    always_comb
    begin
        addend   = '0;
        acc_next = acc_reg;
        case (ctrl.add_sel)
            cvcs_pkg::ADD_LO:
            begin
                addend   = {{60{prod_reg[cvcs_pkg::PROD_W-1]}}, prod_reg};
                acc_next = acc_reg + addend;
            end
            cvcs_pkg::ADD_HI:
            begin
                addend   = {{27{prod_reg[cvcs_pkg::PROD_W-1]}}, prod_reg, 33'd0};
                acc_next = acc_reg + addend;
            end
            cvcs_pkg::ADD_HALF:
            begin
                addend   = HALF_C;
                acc_next = acc_reg + addend;
            end
            cvcs_pkg::ADD_CLEAR:
            begin
                acc_next = '0;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Hold product, upper partial and sum
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_sel != cvcs_pkg::MUL_NONE)
        begin
            prod_reg <= mul_out;
        end
        if (ctrl.mul_sel == cvcs_pkg::MUL_LO)
        begin
            hi_reg <= prod_reg[65:33];
        end
        acc_reg <= acc_next;
    end

    // Drop the fraction bits and saturate to 64 bits
    always_comb
    begin
        shifted = $signed(acc_reg) >>> FRAC_BITS;
        fits    = (&shifted[cvcs_pkg::ACC_W-1:cvcs_pkg::CHISQ_W-1])
                | ~(|shifted[cvcs_pkg::ACC_W-1:cvcs_pkg::CHISQ_W-1]);
        if (fits)
        begin
            result = shifted[cvcs_pkg::CHISQ_W-1:0];
        end
        else if (shifted[cvcs_pkg::ACC_W-1])
        begin
            result = {1'b1, {(cvcs_pkg::CHISQ_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(cvcs_pkg::CHISQ_W-1){1'b1}}};
        end
    end

endmodule
`default_nettype wire

/* sv/covariance_chi_square_core.sv */
// Top level: item intake, sequencer over the quadratic form, result register.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata row,col,matrix_value,observed,expected;
//          |     |                    | s_tuser mode; s_tlast last
//  m_      | out | m_tvalid/m_tready  | m_tdata chisq; m_tuser status
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Matrix and non-last bin items go straight into the stores. A last bin item
// that passes its checks runs P1, P2, P3 per term (N*N terms, N = active_size)
// on the single shared multiplier, then DRAIN, ROUND, DONE; a failing one goes
// straight to DONE. Reset clears the counters and output valid, sets active
// size 1, matrix invalid; payload and stores keep their data. s_tready is
// low while a sum runs or a finished result waits for the output register.
`default_nettype none
module covariance_chi_square_core #(
    parameter int MAX_BINS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // row[5:0], col[11:6], matrix_value[43:12], observed[75:44],
    // expected[107:76], zero[111:108]
    input  wire logic [111:0]                         s_tdata,
    // mode[0]
    input  wire logic                                 s_tuser,
    input  wire logic                                 s_tlast,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // chisq[63:0]
    output logic [cvcs_pkg::CHISQ_W-1:0]              m_tdata,
    // status[1:0]
    output logic [1:0]                                m_tuser,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [cvcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [cvcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    localparam int DEPTH = MAX_BINS * MAX_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [8:0] MAX_C = 9'(MAX_BINS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_P1    = 3'd2;
    localparam logic [2:0] S_P2    = 3'd3;
    localparam logic [2:0] S_P3    = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_ROUND = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                     state_reg, state_next;
    logic [6:0]                     bins_reg, bins_next;
    logic [6:0]                     active_size_reg;
    logic                           matrix_valid_reg;
    logic [IW-1:0]                  i_reg, i_next;
    logic [IW-1:0]                  j_reg, j_next;
    logic                           first_reg, first_next;
    logic                           err_reg, err_next;
    logic [1:0]                     pend_status_reg, pend_status_next;
    logic                           out_valid_reg, out_valid_next;
    logic [cvcs_pkg::CHISQ_W-1:0]   chisq_reg;
    logic [1:0]                     status_reg;
    logic                           out_load;

    logic [5:0]                     row_f;
    logic [5:0]                     col_f;
    logic [cvcs_pkg::MAT_W-1:0]     matrix_value_f;
    logic [31:0]                    observed_f;
    logic [31:0]                    expected_f;
    logic                           accept;
    logic                           row_ok;
    logic                           col_ok;
    logic [6:0]                     count_inc;
    logic [IW-1:0]                  last_idx;
    logic                           rd_en;
    logic [AW-1:0]                  inv_waddr;
    logic [AW-1:0]                  inv_raddr;
    logic [cvcs_pkg::DIFF_W-1:0]    diff_wdata;
    logic [cvcs_pkg::MAT_W-1:0]     m_val;
    logic [cvcs_pkg::DIFF_W-1:0]    d_i;
    logic [cvcs_pkg::DIFF_W-1:0]    d_j;
    logic [cvcs_pkg::CHISQ_W-1:0]   mac_result;
    cvcs_pkg::mac_ctrl_t            mac_ctrl;

    // Unpack input fields
    assign row_f          = s_tdata[5:0];
    assign col_f          = s_tdata[11:6];
    assign matrix_value_f = s_tdata[43:12];
    assign observed_f     = s_tdata[75:44];
    assign expected_f     = s_tdata[107:76];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign row_ok     = {3'b000, row_f} < MAX_C;
    assign col_ok     = {3'b000, col_f} < MAX_C;
    assign inv_waddr  = AW'(row_f) * AW'(MAX_BINS) + AW'(col_f);
    assign diff_wdata = {observed_f[31], observed_f} - {expected_f[31], expected_f};
    assign count_inc  = (bins_reg == 7'd127) ? 7'd127 : bins_reg + 7'd1;
    assign last_idx   = IW'(active_size_reg - 7'd1);
    assign inv_raddr  = AW'(i_next) * AW'(MAX_BINS) + AW'(j_next);

    // Sequence the intake and the sum
    always_comb
    begin
        state_next       = state_reg;
        bins_next        = bins_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        first_next       = first_reg;
        err_next         = err_reg;
        pend_status_next = pend_status_reg;
        rd_en            = 1'b0;
        out_load         = 1'b0;
        mac_ctrl.mul_sel = cvcs_pkg::MUL_NONE;
        mac_ctrl.add_sel = cvcs_pkg::ADD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && s_tuser == cvcs_pkg::MODE_BIN)
                begin
                    bins_next = count_inc;
                    if (s_tlast)
                    begin
                        bins_next = 7'd0;
                        if (!matrix_valid_reg)
                        begin
                            err_next         = 1'b1;
                            pend_status_next = cvcs_pkg::STATUS_NO_INVERSE;
                            state_next       = S_DONE;
                        end
                        else if (active_size_reg == 7'd0
                                 || {2'b00, active_size_reg} > MAX_C
                                 || count_inc != active_size_reg)
                        begin
                            err_next         = 1'b1;
                            pend_status_next = cvcs_pkg::STATUS_MISMATCH;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            err_next         = 1'b0;
                            pend_status_next = cvcs_pkg::STATUS_OK;
                            state_next       = S_START;
                        end
                    end
                end
            end
            S_START:
            begin
                i_next           = '0;
                j_next           = '0;
                first_next       = 1'b1;
                rd_en            = 1'b1;
                mac_ctrl.add_sel = cvcs_pkg::ADD_CLEAR;
                state_next       = S_P1;
            end
            S_P1:
            begin
                mac_ctrl.mul_sel = cvcs_pkg::MUL_DD;
                mac_ctrl.add_sel = first_reg ? cvcs_pkg::ADD_NONE : cvcs_pkg::ADD_HI;
                first_next       = 1'b0;
                state_next       = S_P2;
            end
            S_P2:
            begin
                mac_ctrl.mul_sel = cvcs_pkg::MUL_LO;
                state_next       = S_P3;
            end
            S_P3:
            begin
                mac_ctrl.mul_sel = cvcs_pkg::MUL_HI;
                mac_ctrl.add_sel = cvcs_pkg::ADD_LO;
                if (j_reg == last_idx)
                begin
                    if (i_reg == last_idx)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next     = IW'(i_reg + 1'b1);
                        j_next     = '0;
                        rd_en      = 1'b1;
                        state_next = S_P1;
                    end
                end
                else
                begin
                    j_next     = IW'(j_reg + 1'b1);
                    rd_en      = 1'b1;
                    state_next = S_P1;
                end
            end
            S_DRAIN:
            begin
                mac_ctrl.add_sel = cvcs_pkg::ADD_HI;
                state_next       = S_ROUND;
            end
            S_ROUND:
            begin
                mac_ctrl.add_sel = cvcs_pkg::ADD_HALF;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            bins_reg         <= 7'd0;
            active_size_reg  <= 7'd1;
            matrix_valid_reg <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            first_reg        <= 1'b0;
            err_reg          <= 1'b0;
            pend_status_reg  <= cvcs_pkg::STATUS_OK;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bins_reg        <= bins_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            first_reg       <= first_next;
            err_reg         <= err_next;
            pend_status_reg <= pend_status_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cvcs_pkg::REG_ACTIVE_SIZE:
                    begin
                        active_size_reg <= cfg_data;
                    end
                    cvcs_pkg::REG_MATRIX_VALID:
                    begin
                        matrix_valid_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        active_size_reg <= active_size_reg;
                    end
                endcase
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            chisq_reg  <= err_reg ? '0 : mac_result;
            status_reg <= pend_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = chisq_reg;
    assign m_tuser  = status_reg;

    cvcs_mem #(
        .MAX_BINS (MAX_BINS)
    ) u_mem (
        .clk        (clk),
        .inv_we     (accept && s_tuser == cvcs_pkg::MODE_MATRIX && row_ok && col_ok),
        .inv_waddr  (inv_waddr),
        .inv_wdata  (matrix_value_f),
        .diff_we    (accept && s_tuser == cvcs_pkg::MODE_BIN && row_ok),
        .diff_waddr (IW'(row_f)),
        .diff_wdata (diff_wdata),
        .rd_en      (rd_en),
        .inv_raddr  (inv_raddr),
        .rd_i       (i_next),
        .rd_j       (j_next),
        .m_val      (m_val),
        .d_i        (d_i),
        .d_j        (d_j)
    );

    cvcs_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .d_i    (d_i),
        .d_j    (d_j),
        .m_val  (m_val),
        .result (mac_result)
    );

endmodule
`default_nettype wire
